// ===== design/substring_search_unit_defines.svh =====
// Assertion macros for the substring search unit checker.
`ifndef SUBSTRING_SEARCH_UNIT_DEFINES_SVH
`define SUBSTRING_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ssu_pkg.sv =====
// Shared types and constants for the substring search unit.
`default_nettype none
package ssu_pkg;

    localparam int DATA_W     = 8;
    localparam int SLOT_W     = 4;
    localparam int LEN_CFG_W  = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int POS_OUT_W  = 16;
    localparam int CNT_W      = 17;

    localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE    = 1'd1;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              clear;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] data;
    } cell_ctrl_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] match_position;
        logic [CNT_W-1:0]     match_count;
    } res_t;

endpackage
`default_nettype wire

// ===== design/ssu_cell.sv =====
// One match cell: a pattern byte and the partial-match bit for its prefix.
`default_nettype none
module ssu_cell
    import ssu_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       en,
    input  wire logic       prev_in,
    output logic            hit_next,
    output logic            chain_out
);

    logic [DATA_W-1:0] pat_reg;
    logic              chain_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load && (int'(ctrl.slot) == K)) begin
            pat_reg <= ctrl.data;
        end
    end

    assign hit_next = en & prev_in & (pat_reg == ctrl.data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= 1'b0;
        end else if (ctrl.step) begin
            chain_reg <= ctrl.clear ? 1'b0 : hit_next;
        end
    end

    assign chain_out = chain_reg;

endmodule
`default_nettype wire

// ===== design/ssu_track.sv =====
// Occurrence tracker: text position, first/last start, count and result.
`default_nettype none
module ssu_track
    import ssu_pkg::*;
#(
    parameter int TEXT_MAX = 65536,
    parameter int LW       = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              last,
    input  wire logic              full,
    input  wire logic [LW-1:0]     act_len,
    input  wire logic [MODE_W-1:0] mode,
    output res_t                   res
);

    localparam int POS_W = $clog2(TEXT_MAX);
    localparam int PW1   = POS_W + 1;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] first_reg, first_next;
    logic [POS_W-1:0] lastp_reg, lastp_next;
    logic             any_reg, any_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW1-1:0]   nxt_reg, nxt_next;

    logic [PW1-1:0]   cur1;
    logic [PW1-1:0]   lenx;
    logic [PW1-1:0]   start_w;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] pos_sel;
    logic             hit;
    logic             take;

    always_comb begin
        cur1       = {1'b0, pos_reg} + PW1'(1);
        lenx       = PW1'(act_len);
        hit        = full && (cur1 >= lenx);
        start_w    = cur1 - lenx;
        start      = start_w[POS_W-1:0];
        take       = hit && (start_w >= nxt_reg);
        first_next = (hit && !any_reg) ? start : first_reg;
        lastp_next = hit ? start : lastp_reg;
        any_next   = any_reg | hit;
        cnt_next   = (take && (cnt_reg != CNT_TOP)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        nxt_next   = take ? cur1 : nxt_reg;
        pos_next   = (cur1 < PW1'(TEXT_MAX)) ? cur1[POS_W-1:0] : POS_W'(TEXT_MAX - 1);

        pos_sel    = (mode == MODE_LAST) ? lastp_next : first_next;
        res.found  = any_next;
        if (mode == MODE_COUNT) begin
            res.match_position = '0;
            res.match_count    = cnt_next;
        end else begin
            res.match_position = any_next ? POS_OUT_W'(pos_sel) : '0;
            res.match_count    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            first_reg <= '0;
            lastp_reg <= '0;
            any_reg   <= 1'b0;
            cnt_reg   <= '0;
            nxt_reg   <= '0;
        end else if (step) begin
            if (last) begin
                pos_reg   <= '0;
                first_reg <= '0;
                lastp_reg <= '0;
                any_reg   <= 1'b0;
                cnt_reg   <= '0;
                nxt_reg   <= '0;
            end else begin
                pos_reg   <= pos_next;
                first_reg <= first_next;
                lastp_reg <= lastp_next;
                any_reg   <= any_next;
                cnt_reg   <= cnt_next;
                nxt_reg   <= nxt_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/substring_search_unit.sv =====
// Top level of the streaming substring search unit.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    command, byte_value, pattern_slot, text_end
//   m_       out  m_valid/m_ready    found, match_position, match_count
//   cfg_     in   cfg_we             cfg_addr, cfg_wdata
//
// One input transfer per cycle while s_ready is high; the cell row compares every prefix in parallel.
// The result of a final text byte is registered on its transfer, into the output entry or the second entry.
// A two-entry output buffer keeps s_ready high while one result waits.
// s_ready drops only while both output entries are full.
// Reset (aresetn low, synchronous) clears match bits, tracker and buffer;
// pattern bytes hold no reset value.
`default_nettype none
module substring_search_unit
    import ssu_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 65536
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [DATA_W-1:0]     s_byte_value,
    input  wire logic [SLOT_W-1:0]     s_pattern_slot,
    input  wire logic                  s_text_end,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_found,
    output logic [POS_OUT_W-1:0]       m_match_position,
    output logic [CNT_W-1:0]           m_match_count
);

    localparam int LW = ($clog2(PATTERN_MAX + 1) > LEN_CFG_W) ?
                        $clog2(PATTERN_MAX + 1) : LEN_CFG_W;

    logic [LEN_CFG_W-1:0] len_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [LW-1:0]        len_ext;
    logic [LW-1:0]        act_len;

    cell_ctrl_t             ctrl;
    logic                   s_xfer;
    logic [PATTERN_MAX-1:0] en;
    logic [PATTERN_MAX-1:0] last_mask;
    logic [PATTERN_MAX-1:0] hit_next;
    logic [PATTERN_MAX-1:0] chain;
    logic                   full;
    res_t                   res;

    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= LEN_CFG_W'(1);
            mode_reg <= MODE_FIRST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PATTERN_LENGTH: len_reg  <= cfg_wdata[LEN_CFG_W-1:0];
                REG_SEARCH_MODE:    mode_reg <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len_ext = LW'(len_reg);
        if (len_ext == '0) begin
            act_len = LW'(1);
        end else if (len_ext > LW'(PATTERN_MAX)) begin
            act_len = LW'(PATTERN_MAX);
        end else begin
            act_len = len_ext;
        end
    end

    assign s_ready    = ~skid_valid_reg;
    assign s_xfer     = s_valid & s_ready;
    assign ctrl.load  = s_xfer & (s_command == CMD_LOAD);
    assign ctrl.step  = s_xfer & (s_command == CMD_TEXT);
    assign ctrl.clear = s_text_end;
    assign ctrl.slot  = s_pattern_slot;
    assign ctrl.data  = s_byte_value;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic prev;
        if (k == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_body
            assign prev = chain[k-1];
        end
        assign en[k]        = (LW'(k) < act_len);
        assign last_mask[k] = (LW'(k + 1) == act_len);

        ssu_cell #(
            .K(k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .en       (en[k]),
            .prev_in  (prev),
            .hit_next (hit_next[k]),
            .chain_out(chain[k])
        );
    end

    assign full = |(hit_next & last_mask);

    ssu_track #(
        .TEXT_MAX(TEXT_MAX),
        .LW      (LW)
    ) u_track (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (ctrl.step),
        .last   (s_text_end),
        .full   (full),
        .act_len(act_len),
        .mode   (mode_reg),
        .res    (res)
    );

    assign push = ctrl.step & s_text_end;
    assign pop  = out_valid_reg & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_found          = out_reg.found;
    assign m_match_position = out_reg.match_position;
    assign m_match_count    = out_reg.match_count;

endmodule
`default_nettype wire

// ===== design/ssu_checker.sv =====
// Port-level checker for the substring search unit, bound to the top level.
`default_nettype none
`include "substring_search_unit_defines.svh"
module ssu_checker
    import ssu_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_command,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_found,
    input wire logic [POS_OUT_W-1:0]  m_match_position,
    input wire logic [CNT_W-1:0]      m_match_count
);

    `SSU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found) && $stable(m_match_position) && $stable(m_match_count), "result changed while stalled")
    `SSU_ASSERT_NOW(a_none_zero, aclk, aresetn, m_valid && !m_found, (m_match_position == '0) && (m_match_count == '0), "no match but nonzero fields")
    `SSU_ASSERT_NOW(a_pos_or_cnt, aclk, aresetn, m_valid, (m_match_position == '0) || (m_match_count == '0), "position and count both set")
    `SSU_ASSERT_NEXT(a_load_silent, aclk, aresetn, !m_valid && s_valid && s_ready && (s_command == CMD_LOAD), !m_valid, "pattern load produced a result")

endmodule

bind substring_search_unit ssu_checker u_ssu_checker (.*);
`default_nettype wire
